>>> rtl/wra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_pkg: shared types and constants for the windowed RMS amplitude block
// Holds the controller/datapath command and status structs and defaults.
// ----------------------------------------------------------------------------
package wra_pkg;

    localparam int WindowMaxDefault  = 1024;
    localparam int SampleBitsDefault = 16;
    localparam int LenBits           = 11;
    localparam int OutBits           = 20;
    localparam logic [LenBits-1:0] LenReset = 11'd256;

    typedef struct packed {
        logic load;      // store sample, accumulate sum
        logic clear;     // drop window
        logic rd_issue;  // read store at pass index
        logic dev_start; // start deviation divide
        logic sq_add;    // accumulate squared deviation
        logic fin_start; // start final divide
        logic sqrt_start;// start square root
        logic emit;      // present result
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic win_full;
        logic pass_last;
    } t_status;

endpackage

>>> rtl/wra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_ram: generic single-port RAM
// One address per cycle, read every cycle with an optional write; registered read data.
// ----------------------------------------------------------------------------
module wra_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_datapath: window store, sums, shared divider and square root
// Executes controller commands one step at a time.
// ----------------------------------------------------------------------------
module wra_datapath #(
    parameter int WindowMax  = wra_pkg::WindowMaxDefault,
    parameter int SampleBits = wra_pkg::SampleBitsDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wra_pkg::t_cmd                   i_cmd,
    input  logic signed [SampleBits-1:0]    i_sample,
    input  logic [wra_pkg::LenBits-1:0]     i_len,
    output wra_pkg::t_status                o_status,
    output logic [wra_pkg::OutBits-1:0]     o_rms
);

    localparam int AddrBits = (WindowMax > 1) ? $clog2(WindowMax) : 1;
    localparam int CntBits  = $clog2(WindowMax + 1);
    localparam int LenBits  = wra_pkg::LenBits;
    localparam int SumBits  = SampleBits + CntBits + 1;
    localparam int ProdBits = SampleBits + LenBits + 1;
    localparam int NumBits  = (SumBits > ProdBits ? SumBits : ProdBits) + 1;
    localparam int DevBits  = SampleBits + 2;
    localparam int SqBits   = 2 * DevBits + CntBits;
    localparam int QBits    = SqBits + 8;
    localparam int DBits    = (NumBits > QBits) ? NumBits : QBits;
    localparam int DCntBits = $clog2(DBits + 1);
    localparam int RootBits = (QBits + 1) / 2;
    localparam int RadBits  = 2 * RootBits;
    localparam int SCntBits = $clog2(RootBits + 1);
    localparam int OutBits  = wra_pkg::OutBits;

    logic [CntBits-1:0]            r_fill;
    logic [CntBits-1:0]            r_idx;
    logic signed [SumBits-1:0]     r_sum;
    logic [SqBits-1:0]             r_sq;
    logic [SampleBits-1:0]         w_rdata;
    logic [AddrBits-1:0]           w_addr;
    logic [LenBits-1:0]            w_n;

    // divider
    logic [DBits-1:0]              r_dnum;
    logic [DBits-1:0]              r_drem;
    logic [DBits-1:0]              r_dquo;
    logic [DCntBits-1:0]           r_dcnt;
    logic                          r_dbusy;
    logic                          r_dneg;
    logic                          r_dfin;
    logic [DBits:0]                w_trial;
    logic [DBits-1:0]              w_rem_sh;

    // square root
    logic [RadBits-1:0]            r_rad;
    logic [RootBits+1:0]           r_srem;
    logic [RootBits-1:0]           r_root;
    logic [SCntBits-1:0]           r_scnt;
    logic                          r_sbusy;
    logic                          r_sdone;
    logic [RootBits+1:0]           w_srem_sh;
    logic [RootBits+1:0]           w_strial;

    logic signed [ProdBits-1:0]    w_prod;
    logic signed [NumBits-1:0]     w_num;
    logic [NumBits-1:0]            w_mag;
    logic signed [DevBits-1:0]     w_dev;
    logic [2*DevBits-1:0]          w_dsq;
    logic [RootBits-1:0]           r_out_root;

    assign w_n    = (i_len == '0) ? LenBits'(1)
                  : ((32'(i_len) > WindowMax) ? LenBits'(WindowMax) : i_len);
    assign w_addr = i_cmd.load ? r_fill[AddrBits-1:0] : r_idx[AddrBits-1:0];

    wra_ram #(.Width(SampleBits), .Depth(WindowMax)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_addr  (w_addr),
        .i_wdata (i_sample),
        .o_rdata (w_rdata)
    );

    assign w_prod = $signed(w_rdata) * $signed({1'b0, w_n});
    assign w_num  = NumBits'(w_prod) - NumBits'(r_sum);
    assign w_mag  = w_num[NumBits-1] ? NumBits'(-w_num) : NumBits'(w_num);

    assign w_rem_sh = {r_drem[DBits-2:0], r_dnum[DBits-1]};
    assign w_trial  = {1'b0, w_rem_sh} - (DBits+1)'(w_n);

    assign w_dev = r_dneg ? -$signed(DevBits'(r_dquo)) : $signed(DevBits'(r_dquo));
    assign w_dsq = (2*DevBits)'($unsigned(w_dev < 0 ? -w_dev : w_dev))
                 * (2*DevBits)'($unsigned(w_dev < 0 ? -w_dev : w_dev));

    assign w_srem_sh = {r_srem[RootBits-1:0], r_rad[RadBits-1 -: 2]};
    assign w_strial  = w_srem_sh - {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_dbusy <= 1'b0;
            r_dfin  <= 1'b0;
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_dfin  <= 1'b0;
            r_sdone <= 1'b0;
            if (i_cmd.clear) begin
                r_fill <= '0;
                r_idx  <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end
            if (i_cmd.load) begin
                r_fill <= r_fill + 1'b1;
                r_sum  <= r_sum + SumBits'(i_sample);
            end
            if (i_cmd.rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.dev_start) begin
                r_dnum  <= DBits'(w_mag);
                r_dneg  <= w_num[NumBits-1];
                r_drem  <= '0;
                r_dquo  <= '0;
                r_dcnt  <= DCntBits'(DBits);
                r_dbusy <= 1'b1;
            end else if (i_cmd.fin_start) begin
                r_dnum  <= DBits'({r_sq, 8'h00});
                r_dneg  <= 1'b0;
                r_drem  <= '0;
                r_dquo  <= '0;
                r_dcnt  <= DCntBits'(DBits);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                r_dnum <= {r_dnum[DBits-2:0], 1'b0};
                if (!w_trial[DBits]) begin
                    r_drem <= w_trial[DBits-1:0];
                    r_dquo <= {r_dquo[DBits-2:0], 1'b1};
                end else begin
                    r_drem <= w_rem_sh;
                    r_dquo <= {r_dquo[DBits-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == DCntBits'(1)) begin
                    r_dbusy <= 1'b0;
                    r_dfin  <= 1'b1;
                end
            end
            if (i_cmd.sq_add) begin
                r_sq <= r_sq + SqBits'(w_dsq);
            end
            if (i_cmd.sqrt_start) begin
                r_rad   <= RadBits'(r_dquo[QBits-1:0]);
                r_srem  <= '0;
                r_root  <= '0;
                r_scnt  <= SCntBits'(RootBits);
                r_sbusy <= 1'b1;
            end else if (r_sbusy) begin
                r_rad <= {r_rad[RadBits-3:0], 2'b00};
                if (!w_strial[RootBits+1]) begin
                    r_srem <= w_strial;
                    r_root <= {r_root[RootBits-2:0], 1'b1};
                end else begin
                    r_srem <= w_srem_sh;
                    r_root <= {r_root[RootBits-2:0], 1'b0};
                end
                r_scnt <= r_scnt - 1'b1;
                if (r_scnt == SCntBits'(1)) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_root <= r_root;
        end
    end

    assign o_rms = (RootBits > OutBits && |(r_out_root >> OutBits)) ? '1
                 : OutBits'(r_out_root);

    assign o_status.div_done  = r_dfin;
    assign o_status.sqrt_done = r_sdone;
    assign o_status.win_full  = (r_fill == CntBits'(w_n));
    assign o_status.pass_last = (r_idx == CntBits'(w_n));

endmodule

>>> rtl/wra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wra_ctrl: sequencer for load, deviation pass and final root
// Issues commands to the datapath and owns the request handshake.
// ----------------------------------------------------------------------------
module wra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_wr,
    input  wra_pkg::t_status  i_status,
    output wra_pkg::t_cmd     o_cmd,
    output logic              o_strobe
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD, S_DEV, S_SQ, S_FIN, S_SQRT, S_EMIT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_strobe;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && start;
        o_cmd.clear      = i_cfg_wr || (r_state == S_OUT);
        o_cmd.rd_issue   = (r_state == S_RD);
        o_cmd.dev_start  = (r_state == S_DEV);
        o_cmd.sq_add     = (r_state == S_SQ) && i_status.div_done;
        o_cmd.fin_start  = (r_state == S_FIN);
        o_cmd.sqrt_start = (r_state == S_SQRT) && i_status.div_done;
        o_cmd.emit       = (r_state == S_EMIT) && i_status.sqrt_done;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE:  if (start) begin
                    r_state <= S_CHECK;
                end
                S_CHECK: r_state <= i_status.win_full ? S_RD : S_IDLE;
                S_RD:    r_state <= S_DEV;
                S_DEV:   r_state <= S_SQ;
                S_SQ:    if (i_status.div_done) begin
                    r_state <= i_status.pass_last ? S_FIN : S_RD;
                end
                S_FIN:   r_state <= S_SQRT;
                S_SQRT:  if (i_status.div_done) begin
                    r_state <= S_EMIT;
                end
                S_EMIT:  if (i_status.sqrt_done) begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !busy) else $error("load while busy");
    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_OUT)) else $error("stray strobe");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == S_IDLE) else $error("strobe not idle");

endmodule

>>> rtl/windowed_rms_amplitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_amplitude: window RMS with mean removal, Q.4 output
// Loads a window of samples, re-walks it for deviations, takes the root.
// ----------------------------------------------------------------------------
// channel   | handshake                   | payload
// request   | start & !busy               | i_sample
// result    | o_valid (one cycle)         | o_rms_amplitude
// config    | i_cfg_valid & o_cfg_ready   | i_cfg_data (window_length)
// Non-final samples pass through load, then the window check.
// The sample completing a window of N keeps busy high through one serial divide per
// deviation, a final divide and a serial root (divider width DBits = 55, root width
// RootBits = 28 by default).
// Reset clears control; the store needs no clearing pass.
// The receiver cannot stall: o_valid lasts one cycle.
// ----------------------------------------------------------------------------
module windowed_rms_amplitude #(
    parameter int WindowMax  = wra_pkg::WindowMaxDefault,
    parameter int SampleBits = wra_pkg::SampleBitsDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SampleBits-1:0]      i_sample,
    output logic                              o_valid,
    output logic [wra_pkg::OutBits-1:0]       o_rms_amplitude,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wra_pkg::LenBits-1:0]       i_cfg_data
);

    logic [wra_pkg::LenBits-1:0] r_len;
    logic                        w_cfg_wr;
    wra_pkg::t_cmd               w_cmd;
    wra_pkg::t_status            w_status;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= wra_pkg::LenReset;
        end else if (w_cfg_wr) begin
            r_len <= i_cfg_data;
        end
    end

    wra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cfg_wr (w_cfg_wr),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_strobe (o_valid)
    );

    wra_datapath #(.WindowMax(WindowMax), .SampleBits(SampleBits)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (i_sample),
        .i_len    (r_len),
        .o_status (w_status),
        .o_rms    (o_rms_amplitude)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for windowed_rms_amplitude
// Sends samples through the start/busy request port and predicts each window
// RMS with a local model of the block: the window is stored, the mean is
// removed with truncation toward zero, and the squared deviations are summed
// before a floored Q.4 square root. Results are checked in order. Window length
// is rewritten between phases, zero and over-range values included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WinMax   = wra_pkg::WindowMaxDefault;
    localparam int WdogMax  = 300000;
    localparam int NoExpect = -1;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [15:0]           i_sample;
    logic                         o_valid;
    logic [wra_pkg::OutBits-1:0]  o_rms_amplitude;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [wra_pkg::LenBits-1:0]  i_cfg_data;

    windowed_rms_amplitude uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .o_rms_amplitude (o_rms_amplitude),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // window model
    logic signed [15:0]           win_buf [WinMax];
    longint                       win_sum;
    int                           win_fill;
    int                           win_len;
    logic [wra_pkg::OutBits-1:0]  rms_queue [$];

    int  mismatches, failures, results_seen, requests_sent, windows_cfg;
    int  idle_pct, wdog;
    bit  timed_out;

    typedef struct {
        bit cfg;
        int val;
        int expv;
    } t_row;

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic void set_length(int v);
        win_len  = (v < 1) ? 1 : ((v > WinMax) ? WinMax : v);
        win_sum  = 0;
        win_fill = 0;
    endfunction

    function automatic bit window_rms(logic signed [15:0] s, output logic [19:0] rms);
        longint sq, dev;
        longint unsigned q, r;
        sq = 0;
        rms = '0;
        win_buf[win_fill] = s;
        win_sum += s;
        win_fill++;
        if (win_fill < win_len) return 1'b0;
        for (int i = 0; i < win_len; i++) begin
            dev = (longint'(win_buf[i]) * win_len - win_sum) / win_len;
            sq += dev * dev;
        end
        q = ($unsigned(sq) << 8) / win_len;
        r = floor_sqrt(q);
        if (r > 64'hFFFFF) r = 64'hFFFFF;
        rms = r[19:0];
        win_sum  = 0;
        win_fill = 0;
        return 1'b1;
    endfunction

    task automatic send_sample(logic signed [15:0] s, int forced);
        logic [19:0] rms;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start    <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        if (window_rms(s, rms)) rms_queue.push_back(forced >= 0 ? forced[19:0] : rms);
    endtask

    task automatic write_length(int v);
        start <= 1'b0;
        while (rms_queue.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[10:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_length(v);
        windows_cfg++;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'(int'($urandom_range(40)) - 20);
            2: return 16'(int'($urandom_range(2000)) + 30000);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (rms_queue.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result %0d", o_rms_amplitude);
                mismatches++;
            end else begin
                if (o_rms_amplitude !== rms_queue[0]) begin
                    failures++;
                    if (mismatches < 10)
                        $display("rms mismatch: expected %0d got %0d",
                                 rms_queue[0], o_rms_amplitude);
                    mismatches++;
                end
                void'(rms_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WdogMax && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("FAIL windowed_rms_amplitude");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        int   n_rand, len, cnt;
        start       = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        mismatches = 0; failures = 0; results_seen = 0; requests_sent = 0;
        windows_cfg = 0; idle_pct = 18; wdog = 0; timed_out = 1'b0;
        set_length(int'(wra_pkg::LenReset));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length
        repeat (256) send_sample(rand_sample(), NoExpect);

        rows = '{
            '{1, 1, 0},
            '{0, -32768, 0}, '{0, 32767, 0}, '{0, 0, 0}, '{0, -1, 0},
            '{1, 0, 0},      '{0, 12345, 0},
            '{1, 2, 0},
            '{0, 32767, NoExpect}, '{0, -32768, 524272},
            '{0, 5, NoExpect},     '{0, 5, 0},
            '{0, 0, NoExpect},     '{0, 1, 0},
            '{0, 100, NoExpect},
            '{1, 3, 0},
            '{0, 1, NoExpect}, '{0, 2, NoExpect}, '{0, 3, 13}
        };
        foreach (rows[i]) begin
            if (rows[i].cfg) write_length(rows[i].val);
            else send_sample(16'(rows[i].val), rows[i].expv);
        end

        // over-range length holds at the maximum: no result inside a short run
        write_length(1025);
        repeat (40) send_sample(rand_sample(), NoExpect);

        n_rand = 0;
        while (n_rand < 900) begin
            idle_pct = (n_rand < 300) ? 18 : ((n_rand < 600) ? 77 : 0);
            len = ($urandom_range(11) == 0) ? $urandom_range(1) : $urandom_range(2, 48);
            write_length(len);
            cnt = (len < 1 ? 1 : len) * $urandom_range(1, 4);
            if ($urandom_range(2) == 0) cnt += $urandom_range(len);
            repeat (cnt) begin
                send_sample(rand_sample(), NoExpect);
                n_rand++;
            end
        end

        start <= 1'b0;
        while (rms_queue.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        failures += rms_queue.size();

        $display("%0d samples sent over %0d length settings, %0d window results checked",
                 requests_sent, windows_cfg, results_seen);
        $display("%0d mismatches", mismatches);
        if (failures == 0)
            $display("PASS windowed_rms_amplitude");
        else
            $display("FAIL windowed_rms_amplitude");
        $finish;
    end

endmodule

>>> windowed_rms_amplitude.f
rtl/wra_pkg.sv
rtl/wra_ram.sv
rtl/wra_datapath.sv
rtl/wra_ctrl.sv
rtl/windowed_rms_amplitude.sv
dv/tb_top.sv
